FILE: rtl/nof_pkg.sv
// Shared types, constants and helpers for the normal optical flow block.
// No dependencies.
package nof_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned PIXEL_BITS_DEF = 16;

  localparam int unsigned FW_W       = 11;  // frame_width register
  localparam int unsigned FH_W       = 12;  // frame_height register
  localparam int unsigned TH_W       = 16;  // threshold registers
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned FLOW_W     = 24;  // Q15.8 flow
  localparam int unsigned NUM_SHIFT  = 10;  // numerator scale 1024
  localparam int unsigned GRAD_SHIFT = 4;   // 16 * g^2

  localparam int unsigned MIN_DIM = 3;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST    = FW_W'(640);
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST   = FH_W'(480);
  localparam logic [TH_W-1:0] GRAD_THRESHOLD_RST = TH_W'(256);
  localparam logic [TH_W-1:0] TIME_THRESHOLD_RST = TH_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH    = 2'd0,
    REG_FRAME_HEIGHT   = 2'd1,
    REG_GRAD_THRESHOLD = 2'd2,
    REG_TIME_THRESHOLD = 2'd3
  } cfg_reg_e;

  // quotient magnitude (top bit = at or above 2^23) and sign to saturated Q15.8
  function automatic logic [FLOW_W-1:0] sat_flow(input logic [FLOW_W-1:0] quot,
                                                 input logic neg);
    logic [FLOW_W-1:0] low;
    low = {1'b0, quot[FLOW_W-2:0]};
    if (neg) begin
      sat_flow = quot[FLOW_W-1] ? {1'b1, {(FLOW_W-1){1'b0}}} : FLOW_W'(0) - low;
    end else begin
      sat_flow = quot[FLOW_W-1] ? {1'b0, {(FLOW_W-1){1'b1}}} : low;
    end
  endfunction

endpackage

FILE: rtl/nof_cfg_if.sv
// Register write channel of the normal flow block.
// Uses nof_pkg for widths.
interface nof_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [nof_pkg::CFG_IDX_W-1:0]   index;
  logic [nof_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/nof_pix_if.sv
// Pixel pair input channel of the normal flow block.
// No dependencies.
interface nof_pix_if #(parameter int unsigned PIXEL_BITS = 16);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] old_pixel;
  logic [PIXEL_BITS-1:0] new_pixel;
  modport source (output valid, old_pixel, new_pixel, input ready);
  modport sink   (input valid, old_pixel, new_pixel, output ready);
endinterface

FILE: rtl/nof_flow_if.sv
// Flow result channel of the normal flow block.
// Uses nof_pkg for widths.
interface nof_flow_if;
  logic                              valid;
  logic                              ready;
  logic                              flow_valid;
  logic signed [nof_pkg::FLOW_W-1:0] flow_col;
  logic signed [nof_pkg::FLOW_W-1:0] flow_row;
  logic                              last_of_frame;
  modport source (output valid, flow_valid, flow_col, flow_row, last_of_frame,
                  input ready);
  modport sink   (input valid, flow_valid, flow_col, flow_row, last_of_frame,
                  output ready);
endinterface

FILE: rtl/nof_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nof_ram #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 16
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic                 re_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);
  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

FILE: rtl/nof_win_cell.sv
// One column of the 3x3 sum window: holds top, middle and bottom sums.
// No dependencies.
module nof_win_cell #(
  parameter int unsigned SW = 17
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [3*SW-1:0] col_i,
  output logic [3*SW-1:0] col_o
);
  logic [3*SW-1:0] col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (en_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;
endmodule

FILE: rtl/nof_div_cell.sv
// One quotient bit of the two flow dividers (restoring, shared divisor).
// Uses nof_pkg for FLOW_W.
module nof_div_cell #(
  parameter int unsigned NW = 43,
  parameter int unsigned QW = 35,
  parameter int unsigned K  = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  logic [2*NW+QW+2*nof_pkg::FLOW_W+5-1:0] word_i,
  output logic valid_o,
  output logic [2*NW+QW+2*nof_pkg::FLOW_W+5-1:0] word_o
);
  import nof_pkg::*;

  localparam int unsigned CW = (QW + K > NW) ? QW + K : NW;

  typedef struct packed {
    logic [NW-1:0]     rem_c;
    logic [NW-1:0]     rem_r;
    logic [QW-1:0]     div;
    logic [FLOW_W-1:0] quot_c;
    logic [FLOW_W-1:0] quot_r;
    logic              neg_c;
    logic              neg_r;
    logic              fv;
    logic              qz;
    logic              last;
  } div_word_t;

  div_word_t w_in, w_d, w_q;
  logic [CW-1:0] dsh, rc_ext, rr_ext, rc_sub, rr_sub;
  logic valid_q;

  assign w_in = word_i;

  always_comb begin
    w_d    = w_in;
    dsh    = CW'(w_in.div) << K;
    rc_ext = CW'(w_in.rem_c);
    rr_ext = CW'(w_in.rem_r);
    rc_sub = rc_ext - dsh;
    rr_sub = rr_ext - dsh;
    // once the top bit is set the result saturates; stop iterating
    if (!w_in.quot_c[FLOW_W-1] && rc_ext >= dsh) begin
      w_d.quot_c[K] = 1'b1;
      w_d.rem_c     = rc_sub[NW-1:0];
    end
    if (!w_in.quot_r[FLOW_W-1] && rr_ext >= dsh) begin
      w_d.quot_r[K] = 1'b1;
      w_d.rem_r     = rr_sub[NW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_q <= w_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = w_q;
endmodule

FILE: rtl/normal_optical_flow_pixel.sv
// Top level of the normal optical flow block: line memory, window cells,
// derivative products and a chain of divider cells. Uses nof_pkg,
// nof_*_if interfaces, nof_ram, nof_win_cell and nof_div_cell.
//
//  channel   dir  word
//  cfg_i     in   index, data         register write, always ready
//  pix_i     in   old_pixel,new_pixel one pixel pair, raster order
//  flow_o    out  flow_valid, flow_col, flow_row, last_of_frame
//
// One pixel pair per clock unless the output stalls. After the pixel that
// completes its window, a result passes the line memory read, the window,
// the product stage, FLOW_W divider cells (one quotient bit each) and the
// output register. The whole pipeline freezes only while a result waits
// in the output register and is not taken. Reset clears control state and
// the window; the line memory is not cleared, the first two rows fill it.
module normal_optical_flow_pixel #(
  parameter int unsigned MAX_WIDTH  = nof_pkg::MAX_WIDTH_DEF,
  parameter int unsigned PIXEL_BITS = nof_pkg::PIXEL_BITS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  nof_cfg_if.sink    cfg_i,
  nof_pix_if.sink    pix_i,
  nof_flow_if.source flow_o
);
  import nof_pkg::*;

  localparam int unsigned AW  = $clog2(MAX_WIDTH);
  localparam int unsigned CWW = ($clog2(MAX_WIDTH + 1) > FW_W) ? $clog2(MAX_WIDTH + 1) : FW_W;
  localparam int unsigned SW  = PIXEL_BITS + 1;        // pixel sum, also signed dt
  localparam int unsigned DW  = SW + 1;                // signed sum difference
  localparam int unsigned QW  = 2 * SW + 1;            // |grad|^2
  localparam int unsigned PW  = PIXEL_BITS + SW;       // |dt| * |d|
  localparam int unsigned NW  = PW + NUM_SHIFT;
  localparam int unsigned TW  = (PIXEL_BITS > TH_W) ? PIXEL_BITS : TH_W;
  localparam int unsigned GW  = 2 * TH_W + GRAD_SHIFT;
  localparam int unsigned QCW = (QW > GW) ? QW : GW;
  localparam int unsigned RW  = 3 * SW;                // {line1, line0, dt}
  localparam int unsigned XW  = 2 * NW + QW + 2 * FLOW_W + 5;

  typedef struct packed {
    logic [NW-1:0]     rem_c;
    logic [NW-1:0]     rem_r;
    logic [QW-1:0]     div;
    logic [FLOW_W-1:0] quot_c;
    logic [FLOW_W-1:0] quot_r;
    logic              neg_c;
    logic              neg_r;
    logic              fv;
    logic              qz;
    logic              last;
  } div_word_t;

  // ---------------- configuration registers
  logic [FW_W-1:0] fw_q;
  logic [FH_W-1:0] fh_q;
  logic [TH_W-1:0] gt_q, tt_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= FRAME_WIDTH_RST;
      fh_q <= FRAME_HEIGHT_RST;
      gt_q <= GRAD_THRESHOLD_RST;
      tt_q <= TIME_THRESHOLD_RST;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_FRAME_WIDTH:    fw_q <= cfg_i.data[FW_W-1:0];
        REG_FRAME_HEIGHT:   fh_q <= cfg_i.data[FH_W-1:0];
        REG_GRAD_THRESHOLD: gt_q <= cfg_i.data[TH_W-1:0];
        REG_TIME_THRESHOLD: tt_q <= cfg_i.data[TH_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped frame size
  logic [CWW-1:0] fw_ext, eff_w;
  logic [FH_W-1:0] eff_h;

  always_comb begin
    fw_ext = CWW'(fw_q);
    if (fw_ext < CWW'(MIN_DIM)) begin
      eff_w = CWW'(MIN_DIM);
    end else if (fw_ext > CWW'(MAX_WIDTH)) begin
      eff_w = CWW'(MAX_WIDTH);
    end else begin
      eff_w = fw_ext;
    end
    eff_h = (fh_q < FH_W'(MIN_DIM)) ? FH_W'(MIN_DIM) : fh_q;
  end

  // ---------------- handshake: global advance
  logic adv, acc;
  logic ov_q;

  assign adv         = !ov_q || flow_o.ready;
  assign pix_i.ready = adv;
  assign acc         = pix_i.valid && adv;

  // ---------------- raster counters
  logic [AW-1:0]   col_q;
  logic [FH_W-1:0] row_q;
  logic [CWW-1:0]  col_ext;
  logic            col_wrap, row_wrap, emit_d, last_d;

  assign col_ext  = CWW'(col_q);
  assign col_wrap = col_ext + CWW'(1) >= eff_w;
  assign row_wrap = {1'b0, row_q} + (FH_W+1)'(1) >= {1'b0, eff_h};
  assign emit_d   = row_q >= FH_W'(2) && col_ext >= CWW'(2) &&
                    row_q < eff_h && col_ext < eff_w;
  assign last_d   = row_q == eff_h - FH_W'(1) && col_ext == eff_w - CWW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (acc) begin
      if (col_wrap) begin
        col_q <= '0;
        row_q <= row_wrap ? '0 : row_q + FH_W'(1);
      end else begin
        col_q <= col_q + AW'(1);
      end
    end
  end

  // ---------------- stage A: line memory read in flight
  logic                 va_q, emit_a, last_a;
  logic [AW-1:0]        col_a;
  logic [SW-1:0]        sum_a;
  logic signed [SW-1:0] dt_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (adv) begin
      va_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      col_a  <= col_q;
      sum_a  <= SW'(pix_i.old_pixel) + SW'(pix_i.new_pixel);
      dt_a   <= $signed({1'b0, pix_i.new_pixel}) - $signed({1'b0, pix_i.old_pixel});
      emit_a <= emit_d;
      last_a <= last_d;
    end
  end

  logic [RW-1:0] rd_word;
  logic [SW-1:0] top_a, mid_a, dtl_a;
  logic          step_a;

  assign step_a = va_q && adv;
  assign {top_a, mid_a, dtl_a} = rd_word;

  // line 1 takes the old line 0, line 0 takes this sum, dt line takes this dt
  nof_ram #(.W(RW), .D(MAX_WIDTH)) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (step_a),
    .waddr_i (col_a),
    .wdata_i ({mid_a, sum_a, dt_a}),
    .re_i    (adv),
    .raddr_i (col_q),
    .rdata_o (rd_word)
  );

  // window: cell 0 holds the previous column, cell 1 the one before
  logic [RW-1:0] win0, win1;
  logic [SW-1:0] w0_top, w0_bot, w1_mid;

  nof_win_cell #(.SW(SW)) u_win0 (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(step_a),
    .col_i({top_a, mid_a, sum_a}), .col_o(win0)
  );
  nof_win_cell #(.SW(SW)) u_win1 (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(step_a),
    .col_i(win0), .col_o(win1)
  );

  assign w0_top = win0[3*SW-1:2*SW];
  assign w0_bot = win0[SW-1:0];
  assign w1_mid = win1[2*SW-1:SW];

  // center dt: last row's dt one column back
  logic signed [SW-1:0] dtd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dtd_q <= '0;
    end else if (step_a) begin
      dtd_q <= $signed(dtl_a);
    end
  end

  // ---------------- stage B: derivatives
  logic                 vb_q, last_b;
  logic signed [DW-1:0] dc_b, dr_b;
  logic signed [SW-1:0] cdt_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (adv) begin
      vb_q <= va_q && emit_a;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dc_b   <= $signed({1'b0, mid_a}) - $signed({1'b0, w1_mid});
      dr_b   <= $signed({1'b0, w0_bot}) - $signed({1'b0, w0_top});
      cdt_b  <= dtd_q;
      last_b <= last_a;
    end
  end

  // magnitudes
  logic [DW-1:0]         ndc, ndr;
  logic [SW-1:0]         ndt;
  logic [SW-1:0]         mag_dc, mag_dr;
  logic [PIXEL_BITS-1:0] mag_dt;

  assign ndc    = -dc_b;
  assign ndr    = -dr_b;
  assign ndt    = -cdt_b;
  assign mag_dc = dc_b[DW-1] ? ndc[SW-1:0] : dc_b[SW-1:0];
  assign mag_dr = dr_b[DW-1] ? ndr[SW-1:0] : dr_b[SW-1:0];
  assign mag_dt = cdt_b[SW-1] ? ndt[PIXEL_BITS-1:0] : cdt_b[PIXEL_BITS-1:0];

  // ---------------- stage C: products
  logic                vc_q, last_c, tpass_c, negc_c, negr_c;
  logic [2*SW-1:0]     sqc_c, sqr_c;
  logic [PW-1:0]       numc_c, numr_c;
  logic [2*TH_W-1:0]   g2_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (adv) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqc_c   <= (2*SW)'(mag_dc) * (2*SW)'(mag_dc);
      sqr_c   <= (2*SW)'(mag_dr) * (2*SW)'(mag_dr);
      numc_c  <= PW'(mag_dt) * PW'(mag_dc);
      numr_c  <= PW'(mag_dt) * PW'(mag_dr);
      g2_c    <= (2*TH_W)'(gt_q) * (2*TH_W)'(gt_q);
      tpass_c <= TW'(mag_dt) >= TW'(tt_q);
      negc_c  <= cdt_b[SW-1] == dc_b[DW-1];
      negr_c  <= cdt_b[SW-1] == dr_b[DW-1];
      last_c  <= last_b;
    end
  end

  // threshold test and divider head word
  logic [QW-1:0] q_c;
  div_word_t     head;

  always_comb begin
    q_c         = QW'(sqc_c) + QW'(sqr_c);
    head.rem_c  = {numc_c, {NUM_SHIFT{1'b0}}};
    head.rem_r  = {numr_c, {NUM_SHIFT{1'b0}}};
    head.div    = q_c;
    head.quot_c = '0;
    head.quot_r = '0;
    head.neg_c  = negc_c;
    head.neg_r  = negr_c;
    head.fv     = tpass_c && (QCW'(q_c) >= QCW'({g2_c, {GRAD_SHIFT{1'b0}}}));
    head.qz     = q_c == '0;
    head.last   = last_c;
  end

  // ---------------- divider chain, MSB cell first
  logic [XW-1:0] dw [FLOW_W+1];
  logic          dv [FLOW_W+1];

  assign dw[0] = head;
  assign dv[0] = vc_q;

  for (genvar k = 0; k < FLOW_W; k++) begin : g_div
    nof_div_cell #(.NW(NW), .QW(QW), .K(FLOW_W - 1 - k)) u_cell (
      .clk_i(clk_i), .rst_ni(rst_ni), .en_i(adv),
      .valid_i(dv[k]), .word_i(dw[k]),
      .valid_o(dv[k+1]), .word_o(dw[k+1])
    );
  end

  // ---------------- output register
  div_word_t         tail;
  logic              fv_q, lf_q;
  logic [FLOW_W-1:0] fc_q, fr_q;

  assign tail = dw[FLOW_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (adv) begin
      ov_q <= dv[FLOW_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fv_q <= tail.fv;
      lf_q <= tail.last;
      fc_q <= (tail.fv && !tail.qz) ? sat_flow(tail.quot_c, tail.neg_c) : '0;
      fr_q <= (tail.fv && !tail.qz) ? sat_flow(tail.quot_r, tail.neg_r) : '0;
    end
  end

  assign flow_o.valid         = ov_q;
  assign flow_o.flow_valid    = fv_q;
  assign flow_o.flow_col      = $signed(fc_q);
  assign flow_o.flow_row      = $signed(fr_q);
  assign flow_o.last_of_frame = lf_q;

  // ---------------- checks
  a_zero_when_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !fv_q |-> fc_q == '0 && fr_q == '0)
    else $error("flow nonzero on invalid pixel");

  a_col_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && col_wrap |=> col_q == '0)
    else $error("column counter did not wrap");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> va_q)
    else $error("accepted word lost at stage A");

  a_stall_holds_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    va_q && !adv |=> va_q && $stable(col_a))
    else $error("stage A changed while stalled");

endmodule
